>>> rtl/ued_pkg.sv
// ued_pkg: shared types and constants of the uart embedded event decoder
// no dependencies; imported by the config, core and top-level modules

package ued_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned FlagW     = 4;
  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned CfgAddrW  = 2;

  localparam logic [ByteW-1:0]    EscapeReset = 8'hFF;
  localparam logic [CfgAddrW-1:0] AddrEscape  = 2'd0;

  // escape codes that follow the escape byte
  localparam logic [ByteW-1:0] CodeLiteral = 8'd0;
  localparam logic [ByteW-1:0] CodeEventA  = 8'd1;
  localparam logic [ByteW-1:0] CodeEventB  = 8'd2;

  // line flags as carried in bits 4..1 of a status byte
  typedef struct packed {
    logic break_f;
    logic framing;
    logic parity;
    logic overrun;
  } ued_flags_t;

  // configuration handed from the register block to the decoder
  typedef struct packed {
    logic [ByteW-1:0] escape_char;
  } ued_cfg_t;

endpackage

>>> rtl/ued_in_if.sv
// ued_in_if: valid/ready channel carrying one raw received byte
// depends on ued_pkg for the byte width

interface ued_in_if;
  import ued_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

>>> rtl/ued_out_if.sv
// ued_out_if: valid/ready channel carrying one decoded character and its flags
// depends on ued_pkg for the byte width

interface ued_out_if;
  import ued_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] out_char;
  logic             overrun_flag;
  logic             parity_flag;
  logic             framing_flag;
  logic             break_flag;

  modport source (
    output valid, output out_char, output overrun_flag, output parity_flag,
    output framing_flag, output break_flag, input ready
  );
  modport sink (
    input valid, input out_char, input overrun_flag, input parity_flag,
    input framing_flag, input break_flag, output ready
  );
endinterface

>>> rtl/ued_cfg.sv
// ued_cfg: apb-style register block holding the escape byte
// depends on ued_pkg for address, data widths and the config struct

module ued_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [ued_pkg::CfgAddrW-1:0]   cfg_paddr,
  input  logic [ued_pkg::CfgDataW-1:0]   cfg_pwdata,
  output logic [ued_pkg::CfgDataW-1:0]   cfg_prdata,
  output logic                           cfg_pready,
  output ued_pkg::ued_cfg_t              cfg
);
  import ued_pkg::*;

  logic [ByteW-1:0] escape_r;
  logic [ByteW-1:0] escape_nxt;
  logic             wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    escape_nxt = escape_r;
    if (wr_en && cfg_paddr == AddrEscape) begin
      escape_nxt = cfg_pwdata[ByteW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      escape_r <= EscapeReset;
    end else begin
      escape_r <= escape_nxt;
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr == AddrEscape) begin
      cfg_prdata = {{(CfgDataW-ByteW){1'b0}}, escape_r};
    end
  end

  assign cfg.escape_char = escape_r;
endmodule

>>> rtl/ued_core.sv
// ued_core: escape-sequence phase machine with a registered result stage
// depends on ued_pkg and the ued_in_if / ued_out_if channel interfaces

module ued_core (
  input  logic              clk,
  input  logic              rst_n,
  input  ued_pkg::ued_cfg_t cfg,
  ued_in_if.sink            in_ch,
  ued_out_if.source         out_ch
);
  import ued_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_CODE   = 2'd1,
    PH_STATUS = 2'd2,
    PH_DATA   = 2'd3
  } phase_t;

  phase_t           phase_r, phase_nxt;
  ued_flags_t       held_r, held_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [ByteW-1:0] out_char_r, out_char_nxt;
  ued_flags_t       out_flags_r, out_flags_nxt;

  logic             acc;
  logic             emit;
  logic [ByteW-1:0] emit_char;
  ued_flags_t       emit_flags;
  logic [ByteW-1:0] b;

  assign b           = in_ch.in_byte;
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign acc         = in_ch.valid && in_ch.ready;

  always_comb begin
    phase_nxt  = phase_r;
    held_nxt   = held_r;
    emit       = 1'b0;
    emit_char  = b;
    emit_flags = '0;
    case (phase_r)
      PH_IDLE: begin
        if (b == cfg.escape_char) begin
          phase_nxt = PH_CODE;
        end else begin
          emit = 1'b1;
        end
      end
      PH_CODE: begin
        phase_nxt = PH_IDLE;
        if (b == CodeLiteral) begin
          emit      = 1'b1;
          emit_char = cfg.escape_char;
        end else if (b == CodeEventA || b == CodeEventB) begin
          phase_nxt = PH_STATUS;
        end
      end
      PH_STATUS: begin
        held_nxt = ued_flags_t'(b[FlagW:1]);
        if (b[0]) begin
          phase_nxt = PH_DATA;
        end else begin
          phase_nxt  = PH_IDLE;
          emit       = 1'b1;
          emit_char  = '0;
          emit_flags = ued_flags_t'(b[FlagW:1]);
        end
      end
      PH_DATA: begin
        phase_nxt  = PH_IDLE;
        emit       = 1'b1;
        emit_flags = held_r;
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_flags_nxt = out_flags_r;
    if (acc) begin
      out_valid_nxt = emit;
      if (emit) begin
        out_char_nxt  = emit_char;
        out_flags_nxt = emit_flags;
      end
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (acc) begin
        phase_r <= phase_nxt;
        held_r  <= held_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_char_r  <= out_char_nxt;
    out_flags_r <= out_flags_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.out_char     = out_char_r;
  assign out_ch.overrun_flag = out_flags_r.overrun;
  assign out_ch.parity_flag  = out_flags_r.parity;
  assign out_ch.framing_flag = out_flags_r.framing;
  assign out_ch.break_flag   = out_flags_r.break_f;

  a_escape_to_code: assert property (@(posedge clk) disable iff (!rst_n)
    acc && phase_r == PH_IDLE && b == cfg.escape_char |=> phase_r == PH_CODE && !out_valid_r)
    else $error("escape byte did not open a sequence");

  a_status_to_data: assert property (@(posedge clk) disable iff (!rst_n)
    acc && phase_r == PH_STATUS && b[0] |=> phase_r == PH_DATA && !out_valid_r)
    else $error("status with data bit did not wait for data byte");

  a_plain_clear: assert property (@(posedge clk) disable iff (!rst_n)
    acc && phase_r == PH_IDLE && b != cfg.escape_char
    |=> out_valid_r && out_flags_r == '0 && out_char_r == $past(b))
    else $error("plain byte not passed through with clear flags");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ch.ready)
    else $error("input stalled with empty result stage");
endmodule

>>> rtl/uart_embedded_event_decoder.sv
// uart_embedded_event_decoder: top level of the embedded line-event decoder
// depends on ued_pkg, ued_in_if, ued_out_if, ued_cfg and ued_core

// Decodes a received uart byte stream in which a programmable escape byte
// (reset 0xFF, register 0 at byte address 0) introduces embedded line events.
// A plain byte passes through with clear flags; escape then code 0 gives the
// escape byte as a literal; escape then code 1 or 2 is followed by a status
// byte whose bits 4..1 carry break, framing, parity and overrun, and status
// bit 0 decides whether the next byte is the data character or a zero
// character is reported at once. Any other code is dropped. The parse phase
// is kept between transfers, so a sequence may be split anywhere. One byte
// is taken every cycle: the phase machine updates per accepted byte and the
// result lands in an output register, so a new byte is accepted whenever
// that register is empty or being drained in the same cycle. Each result is
// offered from that register in the cycle after its input transfer. Write
// the escape register only while no sequence is expected to be in flight.

module uart_embedded_event_decoder (
  input  logic                           clk,
  input  logic                           rst_n,
  ued_in_if.sink                         in_ch,
  ued_out_if.source                      out_ch,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [ued_pkg::CfgAddrW-1:0]   cfg_paddr,
  input  logic [ued_pkg::CfgDataW-1:0]   cfg_pwdata,
  output logic [ued_pkg::CfgDataW-1:0]   cfg_prdata,
  output logic                           cfg_pready
);
  import ued_pkg::*;

  // escape byte as seen by the decoder
  ued_cfg_t cfg;

  // register block: apb write in the access phase, pready tied high
  ued_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // phase machine and result register
  ued_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );
endmodule
